FILE: design/swle_pkg.sv
// Shared constants, types and tables for the spectrum waterfall line engine.
// No dependencies; imported by the core, the RAM wrapper's users and the checker.
package swle_pkg;

  localparam int BINS_DEFAULT       = 512;
  localparam int ROWS_DEFAULT       = 230;
  localparam int BAR_HEIGHT_DEFAULT = 170;

  localparam int BIN_W    = 8;
  localparam int WEIGHT_W = 9;
  localparam int LEVEL_W  = 16;
  localparam int COLUMN_W = 9;
  localparam int ROW_W    = 8;
  localparam int COLOR_W  = 8;
  localparam int BAR_W    = 8;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd205;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 9'd256;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = 16'd65280;

  // floor(32*sqrt(k)), k = v - 128 in the third color band
  localparam logic [7:0] GREEN_ROOT [64] = '{
    8'd0,   8'd32,  8'd45,  8'd55,  8'd64,  8'd71,  8'd78,  8'd84,
    8'd90,  8'd96,  8'd101, 8'd106, 8'd110, 8'd115, 8'd119, 8'd123,
    8'd128, 8'd131, 8'd135, 8'd139, 8'd143, 8'd146, 8'd150, 8'd153,
    8'd156, 8'd160, 8'd163, 8'd166, 8'd169, 8'd172, 8'd175, 8'd178,
    8'd181, 8'd183, 8'd186, 8'd189, 8'd192, 8'd194, 8'd197, 8'd199,
    8'd202, 8'd204, 8'd207, 8'd209, 8'd212, 8'd214, 8'd217, 8'd219,
    8'd221, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232, 8'd235, 8'd237,
    8'd239, 8'd241, 8'd243, 8'd245, 8'd247, 8'd249, 8'd251, 8'd253
  };

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic                last;
  } pixel_t;

endpackage

FILE: design/swle_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds when no read is issued. No dependencies.
module swle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/spectrum_waterfall_line_engine_core.sv
// Each bin passes stages s1, s2, s3, s4 and the output register; one bin per cycle sustained while out_ready is high.
// The smoother store is one RAM read at accept and written back one stage later; a bin
// touches its entry once per line, so read and write of the same entry never overlap.
// Reset (rst, synchronous) clears the pipeline, bin counter, row pointer (ROWS-1) and weight (205).
// The store is not swept: an epoch flag makes the first line after reset read zero.
// Depends on swle_pkg and swle_ram.
module spectrum_waterfall_line_engine_core
  import swle_pkg::*;
#(
  parameter int BINS       = BINS_DEFAULT,
  parameter int ROWS       = ROWS_DEFAULT,
  parameter int BAR_HEIGHT = BAR_HEIGHT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [WEIGHT_W-1:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BIN_W-1:0]    bin_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COLUMN_W-1:0] pixel_column,
  output logic [ROW_W-1:0]    pixel_row,
  output logic [COLOR_W-1:0]  red,
  output logic [COLOR_W-1:0]  green,
  output logic [COLOR_W-1:0]  blue,
  output logic [LEVEL_W-1:0]  smoothed_level,
  output logic [BAR_W-1:0]    bar_height,
  output logic                end_of_line
);

  localparam int CNT_W  = $clog2(BINS);
  localparam int RPTR_W = $clog2(ROWS);
  localparam int CEXT_W = (CNT_W > COLUMN_W) ? CNT_W : COLUMN_W;
  localparam int REXT_W = (RPTR_W > ROW_W) ? RPTR_W : ROW_W;
  localparam int BH_W   = $clog2(BAR_HEIGHT + 1);
  localparam int P_W    = LEVEL_W + BH_W;
  localparam int Q_W    = P_W - 8;
  localparam int EST_W  = Q_W - 7;
  localparam int BF_W   = (EST_W + 1 > BAR_W + 1) ? EST_W + 1 : BAR_W + 1;
  localparam logic [CNT_W-1:0]  LAST_COL = CNT_W'(BINS - 1);
  localparam logic [RPTR_W-1:0] TOP_ROW  = RPTR_W'(ROWS - 1);

  // configuration and line position
  logic [WEIGHT_W-1:0] weight;
  logic [CNT_W-1:0]    bin_counter;
  logic [RPTR_W-1:0]   row_pointer;
  logic                first_line;

  // pipeline
  logic                s1_valid, s2_valid, s3_valid, s4_valid;
  logic                s1_ready, s2_ready, s3_ready, s4_ready, o_ready;
  logic [BIN_W-1:0]    s1_bin;
  logic [CNT_W-1:0]    s1_col;
  logic                s1_zero;
  pixel_t              s1_pix_next, s1_pix, s2_pix, s3_pix, s4_pix, out_pix;
  logic [LEVEL_W-1:0]  s2_level, s3_level, s4_level, out_level;
  logic [Q_W-1:0]      s3_q, s4_q;
  logic [EST_W-1:0]    s4_est;
  logic [BAR_W-1:0]    out_bar;

  logic                accept;
  logic                last_col;
  logic [LEVEL_W-1:0]  ram_rdata;
  logic [LEVEL_W-1:0]  old_level;
  logic [WEIGHT_W-1:0] w_eff;
  logic [WEIGHT_W-1:0] w_new;
  logic [16:0]         new_part;
  logic [24:0]         old_prod;
  logic [17:0]         level_sum;
  logic [LEVEL_W-1:0]  level_next;
  logic [P_W-1:0]      bar_prod;
  logic [Q_W+8:0]      q_mul;
  logic [EST_W+7:0]    est_mul;
  logic [Q_W-1:0]      rem_full;
  logic [8:0]          rem;
  logic [BF_W-1:0]     bar_full;
  logic [BAR_W-1:0]    bar_next;
  logic [CEXT_W-1:0]   col_ext;
  logic [REXT_W-1:0]   row_ext;
  logic [9:0]          blue_raw;
  logic [9:0]          v_ext;

  assign o_ready  = !out_valid || out_ready;
  assign s4_ready = !s4_valid || o_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign accept   = in_valid && in_ready;
  assign last_col = (bin_counter == LAST_COL);

  swle_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (BINS)
  ) u_store (
    .clk   (clk),
    .we    (s1_valid && s2_ready),
    .waddr (s1_col),
    .wdata (level_next),
    .re    (accept),
    .raddr (bin_counter),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RESET;
    end else if (cfg_wr_en) begin
      weight <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter <= '0;
      row_pointer <= TOP_ROW;
      first_line  <= 1'b1;
    end else if (accept) begin
      if (last_col) begin
        bin_counter <= '0;
        first_line  <= 1'b0;
        if (row_pointer == '0 || row_pointer > TOP_ROW) begin
          row_pointer <= TOP_ROW;
        end else begin
          row_pointer <= row_pointer - 1'b1;
        end
      end else begin
        bin_counter <= bin_counter + 1'b1;
      end
    end
  end

  // heat color from the raw bin
  always_comb begin
    col_ext = CEXT_W'(bin_counter);
    row_ext = REXT_W'(row_pointer);
    v_ext   = 10'(bin_value);
    s1_pix_next        = '0;
    s1_pix_next.column = col_ext[COLUMN_W-1:0];
    s1_pix_next.row    = row_ext[ROW_W-1:0];
    s1_pix_next.last   = last_col;
    if (bin_value < 8'd128) begin
      blue_raw = 10'd70 + ((10'd3 * v_ext) >> 1);
    end else begin
      blue_raw = 10'd512 - (v_ext << 1);
    end
    s1_pix_next.blue = (blue_raw > 10'd255) ? 8'd255 : blue_raw[7:0];
    if (bin_value < 8'd64) begin
      s1_pix_next.red   = 8'd0;
      s1_pix_next.green = 8'd0;
    end else if (bin_value < 8'd128) begin
      s1_pix_next.red   = 8'(10'd3 * v_ext - 10'd192);
      s1_pix_next.green = 8'd0;
    end else if (bin_value < 8'd192) begin
      s1_pix_next.red   = bin_value + 8'd64;
      s1_pix_next.green = GREEN_ROOT[bin_value[5:0]];
    end else begin
      s1_pix_next.red   = 8'd255;
      s1_pix_next.green = 8'd255;
    end
  end

  // smoother update on the RAM read data
  always_comb begin
    old_level  = s1_zero ? '0 : ram_rdata;
    w_eff      = (weight > WEIGHT_MAX) ? WEIGHT_MAX : weight;
    w_new      = WEIGHT_MAX - w_eff;
    new_part   = 17'(s1_bin) * 17'(w_new);
    old_prod   = 25'(old_level) * 25'(w_eff);
    level_sum  = 18'(new_part) + 18'(old_prod[24:8]);
    level_next = (level_sum > 18'(LEVEL_MAX)) ? LEVEL_MAX : level_sum[LEVEL_W-1:0];
  end

  // bar = floor(level*BAR_HEIGHT/65280): >>8, then /255 by reciprocal 257/65536 and one fix-up
  always_comb begin
    bar_prod = P_W'(s2_level) * P_W'(BAR_HEIGHT);
    q_mul    = (Q_W + 9)'(s3_q) + ((Q_W + 9)'(s3_q) << 8);
    est_mul  = (EST_W + 8)'(s4_est) * (EST_W + 8)'(255);
    rem_full = s4_q - Q_W'(est_mul);
    rem      = rem_full[8:0];
    bar_full = BF_W'(s4_est) + ((rem >= 9'd255) ? BF_W'(1) : BF_W'(0));
    bar_next = (bar_full > BF_W'(255)) ? 8'd255 : bar_full[BAR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (s4_ready) begin
        s4_valid <= s3_valid;
      end
      if (o_ready) begin
        out_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bin  <= bin_value;
      s1_col  <= bin_counter;
      s1_zero <= first_line;
      s1_pix  <= s1_pix_next;
    end
    if (s1_valid && s2_ready) begin
      s2_level <= level_next;
      s2_pix   <= s1_pix;
    end
    if (s2_valid && s3_ready) begin
      s3_level <= s2_level;
      s3_q     <= bar_prod[P_W-1:8];
      s3_pix   <= s2_pix;
    end
    if (s3_valid && s4_ready) begin
      s4_level <= s3_level;
      s4_q     <= s3_q;
      s4_est   <= q_mul[Q_W+8:16];
      s4_pix   <= s3_pix;
    end
    if (s4_valid && o_ready) begin
      out_level <= s4_level;
      out_bar   <= bar_next;
      out_pix   <= s4_pix;
    end
  end

  assign pixel_column   = out_pix.column;
  assign pixel_row      = out_pix.row;
  assign red            = out_pix.red;
  assign green          = out_pix.green;
  assign blue           = out_pix.blue;
  assign end_of_line    = out_pix.last;
  assign smoothed_level = out_level;
  assign bar_height     = out_bar;

endmodule

FILE: design/swle_checker.sv
// Port-level checks for the spectrum waterfall line engine, bound to the core.
// Depends on swle_pkg.
module swle_checker
  import swle_pkg::*;
#(
  parameter int BINS       = BINS_DEFAULT,
  parameter int ROWS       = ROWS_DEFAULT,
  parameter int BAR_HEIGHT = BAR_HEIGHT_DEFAULT
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [COLUMN_W-1:0] pixel_column,
  input logic [LEVEL_W-1:0]  smoothed_level,
  input logic [BAR_W-1:0]    bar_height,
  input logic                end_of_line
);

  localparam int BAR_LIMIT = (BAR_HEIGHT > 255) ? 255 : BAR_HEIGHT;
  localparam logic [COLUMN_W-1:0] LAST_COL = COLUMN_W'(BINS - 1);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(smoothed_level) && $stable(pixel_column))
    else $error("result transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_eol_column: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_line |-> pixel_column == LAST_COL)
    else $error("end of line on a column other than the last");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> smoothed_level <= LEVEL_MAX)
    else $error("smoothed level above full scale");

  a_bar_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bar_height <= BAR_W'(BAR_LIMIT))
    else $error("bar height above limit");

endmodule

bind spectrum_waterfall_line_engine_core swle_checker #(
  .BINS       (BINS),
  .ROWS       (ROWS),
  .BAR_HEIGHT (BAR_HEIGHT)
) u_swle_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .pixel_column   (pixel_column),
  .smoothed_level (smoothed_level),
  .bar_height     (bar_height),
  .end_of_line    (end_of_line)
);

FILE: tb/waterfall_pixel_checker.sv
// Checker for the spectrum waterfall line engine: follows the bin and pixel channels,
// predicts each pixel transaction and compares it field by field with the block's output.
// Depends on swle_pkg; instantiated beside the core by spectrum_waterfall_line_engine_core_test.
module waterfall_pixel_checker
  import swle_pkg::*;
#(
  parameter int BINS       = BINS_DEFAULT,
  parameter int ROWS       = ROWS_DEFAULT,
  parameter int BAR_HEIGHT = BAR_HEIGHT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [WEIGHT_W-1:0] cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [BIN_W-1:0]    bin_value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [COLUMN_W-1:0] pixel_column,
  input  logic [ROW_W-1:0]    pixel_row,
  input  logic [COLOR_W-1:0]  red,
  input  logic [COLOR_W-1:0]  green,
  input  logic [COLOR_W-1:0]  blue,
  input  logic [LEVEL_W-1:0]  smoothed_level,
  input  logic [BAR_W-1:0]    bar_height,
  input  logic                end_of_line,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pixel_t              px;
    logic [LEVEL_W-1:0]  level;
    logic [BAR_W-1:0]    bar;
  } bin_pixel_t;

  logic [LEVEL_W-1:0]  level_mem [BINS];
  logic [WEIGHT_W-1:0] weight;
  int unsigned         col_pos;
  int unsigned         row_pos;
  bin_pixel_t          expected_pixels [$];

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [LEVEL_W-1:0] got,
                             input logic [LEVEL_W-1:0] want);
    if (got !== want)
      report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic predict_pixel(input logic [BIN_W-1:0] bin);
    bin_pixel_t  p;
    int unsigned v, w, fresh, bar, k, g, b;
    v = 32'(bin);
    w = (weight > 9'd256) ? 256 : 32'(weight);
    if (col_pos >= BINS)
      col_pos = 0;
    fresh = v * (256 - w) + ((level_mem[col_pos] * w) >> 8);
    if (fresh > LEVEL_MAX)
      fresh = LEVEL_MAX;
    level_mem[col_pos] = LEVEL_W'(fresh);
    bar = (fresh * BAR_HEIGHT) / 65280;
    if (bar > 255)
      bar = 255;

    p.px.green = '0;
    if (v < 64) begin
      p.px.red = '0;
      b = 70 + ((3 * v) >> 1);
    end else if (v < 128) begin
      p.px.red = COLOR_W'(3 * v - 192);
      b = 70 + ((3 * v) >> 1);
    end else if (v < 192) begin
      p.px.red = COLOR_W'(v + 64);
      // floor(32*sqrt(k)) == floor(sqrt(1024*k))
      k = v - 128;
      g = 0;
      while ((g + 1) * (g + 1) <= 1024 * k)
        g++;
      p.px.green = COLOR_W'(g);
      b = 512 - 2 * v;
    end else begin
      p.px.red   = 8'd255;
      p.px.green = 8'd255;
      b = 512 - 2 * v;
    end
    p.px.blue   = (b > 255) ? 8'd255 : COLOR_W'(b);
    p.px.column = COLUMN_W'(col_pos);
    p.px.row    = ROW_W'(row_pos);
    p.px.last   = (col_pos == BINS - 1);
    p.level     = LEVEL_W'(fresh);
    p.bar       = BAR_W'(bar);
    expected_pixels.push_back(p);

    if (p.px.last) begin
      col_pos = 0;
      row_pos = (row_pos == 0 || row_pos >= ROWS) ? ROWS - 1 : row_pos - 1;
    end else begin
      col_pos++;
    end
  endtask

  always @(posedge clk) begin
    bin_pixel_t want;
    if (rst) begin
      foreach (level_mem[i])
        level_mem[i] = '0;
      col_pos = 0;
      row_pos = ROWS - 1;
      weight  = WEIGHT_RESET;
      expected_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report("pixel transaction with nothing expected");
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_column", LEVEL_W'(pixel_column), LEVEL_W'(want.px.column));
          check_field("pixel_row", LEVEL_W'(pixel_row), LEVEL_W'(want.px.row));
          check_field("red", LEVEL_W'(red), LEVEL_W'(want.px.red));
          check_field("green", LEVEL_W'(green), LEVEL_W'(want.px.green));
          check_field("blue", LEVEL_W'(blue), LEVEL_W'(want.px.blue));
          check_field("smoothed_level", smoothed_level, want.level);
          check_field("bar_height", LEVEL_W'(bar_height), LEVEL_W'(want.bar));
          check_field("end_of_line", LEVEL_W'(end_of_line), LEVEL_W'(want.px.last));
        end
      end
      if (cfg_wr_en)
        weight = cfg_wr_data;
      if (in_valid && in_ready)
        predict_pixel(bin_value);
    end
    pending = expected_pixels.size();
  end

endmodule

FILE: tb/spectrum_waterfall_line_engine_core_test.sv
// Top of the waterfall line engine testbench: clock, reset, bin stimulus, weight writes and
// output back-pressure, with the verdict taken from waterfall_pixel_checker.
// Depends on swle_pkg, spectrum_waterfall_line_engine_core and waterfall_pixel_checker.
module spectrum_waterfall_line_engine_core_test
  import swle_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [BIN_W-1:0] EDGE_BINS [24] = '{
    8'd0,   8'd1,   8'd2,   8'd63,  8'd64,  8'd65,  8'd100, 8'd123,
    8'd124, 8'd125, 8'd126, 8'd127, 8'd128, 8'd129, 8'd130, 8'd160,
    8'd170, 8'd191, 8'd192, 8'd193, 8'd200, 8'd254, 8'd255, 8'd85
  };
  localparam logic [WEIGHT_W-1:0] PHASE_WEIGHTS [7] = '{
    9'd0, 9'd511, 9'd256, 9'd300, 9'd1, 9'd128, 9'd255
  };
  localparam logic [WEIGHT_W-1:0] PRESSURE_WEIGHT = 9'd128;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [WEIGHT_W-1:0] cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BIN_W-1:0]    bin_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COLUMN_W-1:0] pixel_column;
  logic [ROW_W-1:0]    pixel_row;
  logic [COLOR_W-1:0]  red;
  logic [COLOR_W-1:0]  green;
  logic [COLOR_W-1:0]  blue;
  logic [LEVEL_W-1:0]  smoothed_level;
  logic [BAR_W-1:0]    bar_height;
  logic                end_of_line;
  int                  errors;
  int                  pending;

  int                  burst_left = 0;
  bit                  steady = 1'b0;
  int                  hold_asks = 0;
  logic [BIN_W-1:0]    last_bin = '0;

  always #1 clk = ~clk;

  spectrum_waterfall_line_engine_core dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .bin_value(bin_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_column(pixel_column), .pixel_row(pixel_row),
    .red(red), .green(green), .blue(blue),
    .smoothed_level(smoothed_level), .bar_height(bar_height),
    .end_of_line(end_of_line)
  );

  waterfall_pixel_checker u_pixel_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .bin_value(bin_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_column(pixel_column), .pixel_row(pixel_row),
    .red(red), .green(green), .blue(blue),
    .smoothed_level(smoothed_level), .bar_height(bar_height),
    .end_of_line(end_of_line),
    .errors(errors), .pending(pending)
  );

  task automatic send_bin(input logic [BIN_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    bin_value <= v;
    last_bin = v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_bins(input int n);
    logic [BIN_W-1:0] v;
    repeat (n) begin
      case ($urandom_range(0, 9))
        7:       v = EDGE_BINS[$urandom_range(0, 23)];
        8, 9:    v = last_bin;
        default: v = BIN_W'($urandom_range(0, 255));
      endcase
      send_bin(v);
    end
  endtask

  // drain every outstanding transaction, then give the pipeline time to empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_weight(input logic [WEIGHT_W-1:0] w);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : receiver
    int mode, left, hold_left, tick, hold_done;
    bit rdy;
    mode = 0;
    left = 0;
    hold_left = 0;
    tick = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        hold_left = 150;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 64);
      end
      left--;
      case (mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (tick % 3 != 2);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (EDGE_BINS[i])
      send_bin(EDGE_BINS[i]);
    random_bins(150);

    foreach (PHASE_WEIGHTS[i]) begin
      set_weight(PHASE_WEIGHTS[i]);
      if (PHASE_WEIGHTS[i] == PRESSURE_WEIGHT) begin
        steady = 1'b1;
        hold_asks++;
        random_bins(60);
        steady = 1'b0;
      end
      random_bins(150);
    end
    set_weight(WEIGHT_W'($urandom_range(0, 511)));
    random_bins(150);

    settle();
    repeat (8) @(negedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
